// File: rtl/escp_pkg.sv
`default_nettype none

package escp_pkg;

    localparam int CHANNELS   = 4;
    localparam int PULSE_BITS = 16;
    localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int LEVEL_BITS = 4;

    typedef logic [PULSE_BITS-1:0] t_pulse;
    typedef logic [15:0]           t_count;
    typedef logic [7:0]            t_channel;

    typedef logic [2:0] t_op;
    localparam t_op OP_TICK    = 3'd0;
    localparam t_op OP_LOCK    = 3'd1;
    localparam t_op OP_ARM     = 3'd2;
    localparam t_op OP_SET_ONE = 3'd3;
    localparam t_op OP_SET_ALL = 3'd4;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK          = 2'd0;
    localparam t_status ST_BAD_CHANNEL = 2'd1;
    localparam t_status ST_LOCKED      = 2'd2;
    localparam t_status ST_ARM_FAILED  = 2'd3;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_MIN_PULSE = 2'd0;
    localparam t_cfg_idx CFG_MAX_PULSE = 2'd1;
    localparam t_cfg_idx CFG_PERIOD    = 2'd2;

    localparam t_pulse RST_MIN_PULSE = t_pulse'(1000);
    localparam t_pulse RST_MAX_PULSE = t_pulse'(2000);
    localparam t_count RST_PERIOD    = 16'd2500;

    typedef struct packed {
        t_status                 status;
        logic                    armed;
        logic [LEVEL_BITS-1:0]   pwm_levels;
        t_pulse                  pulse_readback;
    } t_result;

    function automatic t_pulse clamp_pulse(t_pulse p, t_pulse lo, t_pulse hi);
        t_pulse r;
        if (p < lo) begin
            r = lo;
        end else if (p > hi) begin
            r = hi;
        end else begin
            r = p;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/escp_out_buf.sv
`default_nettype none

module escp_out_buf (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire escp_pkg::t_result i_data,
    output logic                   o_full,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output escp_pkg::t_result      o_data
);
    import escp_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    w_take;

    assign w_take  = r_out_valid && !i_stall;
    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_take) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            if (!r_out_valid) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_push) begin
                r_out <= i_data;
            end
        end else if (i_push) begin
            if (!r_out_valid) begin
                r_out <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/esc_pwm_arming_controller.sv
// Path from input beat to result beat: input register, then result register.
// Throughput: one beat per cycle; a two-entry result buffer absorbs output stalls,
// and input stall rises only when that buffer is full.
// Reset (synchronous, active low): disarmed, counter zero, all pulses 1000,
// min/max/period registers 1000/2000/2500, no result pending.
`default_nettype none

module esc_pwm_arming_controller (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [2:0]            i_operation,
    input  wire logic [7:0]            i_channel,
    input  wire escp_pkg::t_pulse      i_pulse_1,
    input  wire escp_pkg::t_pulse      i_pulse_2,
    input  wire escp_pkg::t_pulse      i_pulse_3,
    input  wire escp_pkg::t_pulse      i_pulse_4,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [1:0]                 o_status,
    output logic                       o_armed,
    output logic [3:0]                 o_pwm_levels,
    output escp_pkg::t_pulse           o_pulse_readback,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [1:0]            i_cfg_index,
    input  wire logic [15:0]           i_cfg_data
);
    import escp_pkg::*;

    // configuration
    t_pulse r_min;
    t_pulse r_max;
    t_count r_period;

    // input register
    logic     r_in_valid;
    t_op      r_op;
    t_channel r_channel;
    t_pulse   r_pulse [4];

    // block state
    t_pulse r_staged [CHANNELS];
    t_pulse r_active [CHANNELS];
    t_count r_cnt;
    logic   r_armed;

    t_pulse n_staged [CHANNELS];
    t_pulse n_active [CHANNELS];
    t_count n_cnt;
    logic   n_armed;

    logic     w_full;
    logic     w_fire;
    t_count   w_period;
    t_count   w_cnt_inc;
    logic     w_ch_ok;
    t_channel w_ch_m1;
    logic [CH_IDX_W-1:0] w_ch_idx;
    t_pulse   w_one;
    t_pulse   w_req [CHANNELS];
    logic     w_any_above;
    logic     w_all_min;
    t_status  w_status;
    t_result  w_res;
    t_result  w_out;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = w_full;
    assign w_fire      = r_in_valid && !w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min    <= RST_MIN_PULSE;
            r_max    <= RST_MAX_PULSE;
            r_period <= RST_PERIOD;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MIN_PULSE: r_min    <= t_pulse'(i_cfg_data);
                CFG_MAX_PULSE: r_max    <= t_pulse'(i_cfg_data);
                CFG_PERIOD:    r_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!w_full) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_full && i_in_valid) begin
            r_op       <= i_operation;
            r_channel  <= i_channel;
            r_pulse[0] <= i_pulse_1;
            r_pulse[1] <= i_pulse_2;
            r_pulse[2] <= i_pulse_3;
            r_pulse[3] <= i_pulse_4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_staged[i] <= RST_MIN_PULSE;
                r_active[i] <= RST_MIN_PULSE;
            end
            r_cnt   <= '0;
            r_armed <= 1'b0;
        end else if (w_fire) begin
            r_staged <= n_staged;
            r_active <= n_active;
            r_cnt    <= n_cnt;
            r_armed  <= n_armed;
        end
    end

    assign w_period  = (r_period == '0) ? 16'd1 : r_period;
    assign w_cnt_inc = r_cnt + 16'd1;
    assign w_ch_ok   = (r_channel >= 8'd1) && (r_channel <= 8'(CHANNELS));
    assign w_ch_m1   = r_channel - 8'd1;
    assign w_ch_idx  = w_ch_m1[CH_IDX_W-1:0];
    assign w_one     = clamp_pulse(r_pulse[0], r_min, r_max);

    always_comb begin
        w_any_above = 1'b0;
        w_all_min   = 1'b1;
        for (int i = 0; i < CHANNELS; i++) begin
            w_req[i] = clamp_pulse(r_pulse[(i < 3) ? i : 3], r_min, r_max);
            if (w_req[i] > r_min) begin
                w_any_above = 1'b1;
            end
            if (r_staged[i] != r_min) begin
                w_all_min = 1'b0;
            end
        end
    end

    always_comb begin
        n_staged = r_staged;
        n_active = r_active;
        n_cnt    = r_cnt;
        n_armed  = r_armed;
        w_status = ST_OK;
        case (r_op)
            OP_TICK: begin
                if (w_cnt_inc >= w_period) begin
                    n_cnt    = '0;
                    n_active = r_staged;
                end else begin
                    n_cnt = w_cnt_inc;
                end
            end
            OP_LOCK: begin
                for (int i = 0; i < CHANNELS; i++) begin
                    n_staged[i] = r_min;
                end
                n_armed = 1'b0;
            end
            OP_ARM: begin
                if (w_all_min) begin
                    n_armed = 1'b1;
                end else begin
                    for (int i = 0; i < CHANNELS; i++) begin
                        n_staged[i] = r_min;
                    end
                    n_armed  = 1'b0;
                    w_status = ST_ARM_FAILED;
                end
            end
            OP_SET_ONE: begin
                if (!w_ch_ok) begin
                    w_status = ST_BAD_CHANNEL;
                end else if (!r_armed && (w_one > r_min)) begin
                    w_status = ST_LOCKED;
                end else begin
                    n_staged[w_ch_idx] = w_one;
                end
            end
            OP_SET_ALL: begin
                if (!r_armed && w_any_above) begin
                    w_status = ST_LOCKED;
                end else begin
                    n_staged = w_req;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        w_res.status     = w_status;
        w_res.armed      = n_armed;
        w_res.pwm_levels = '0;
        for (int i = 0; i < CHANNELS && i < LEVEL_BITS; i++) begin
            w_res.pwm_levels[i] = (n_cnt < n_active[i]);
        end
        w_res.pulse_readback = w_ch_ok ? n_staged[w_ch_idx] : '0;
    end

    escp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fire),
        .i_data  (w_res),
        .o_full  (w_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (w_out)
    );

    assign o_status         = w_out.status;
    assign o_armed          = w_out.armed;
    assign o_pwm_levels     = w_out.pwm_levels;
    assign o_pulse_readback = w_out.pulse_readback;

endmodule

`default_nettype wire

// File: rtl/escp_checker.sv
`default_nettype none

module escp_checker (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  o_in_stall,
    input  wire logic                  o_out_valid,
    input  wire logic                  i_out_stall,
    input  wire logic [1:0]            o_status,
    input  wire logic                  o_armed,
    input  wire logic [3:0]            o_pwm_levels,
    input  wire escp_pkg::t_pulse      o_pulse_readback
);
    import escp_pkg::*;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_stall_needs_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result pending");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_armed) && $stable(o_pwm_levels) && $stable(o_pulse_readback))
        else $error("stalled result beat changed");

    a_refused_disarmed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_status == ST_LOCKED) || (o_status == ST_ARM_FAILED)) |-> !o_armed)
        else $error("refusal or failed arm reported while armed");

endmodule

bind esc_pwm_arming_controller escp_checker u_escp_checker (.*);

`default_nettype wire

// File: tb/tb_esc_pwm_arming_controller.sv
`default_nettype none

module tb_esc_pwm_arming_controller;
    timeunit 1ns;
    timeprecision 1ps;

    import escp_pkg::*;

    localparam t_op      OP_RSVD_5    = 3'd5;
    localparam t_op      OP_RSVD_6    = 3'd6;
    localparam t_op      OP_RSVD_7    = 3'd7;
    localparam t_cfg_idx CFG_SPARE    = 2'd3;
    localparam int       CYCLE_LIMIT  = 200000;
    localparam int       DRAIN_CYCLES = 4;
    localparam int       HOLD_CYCLES  = 40;
    localparam int       NUM_PHASES   = 10;
    localparam int       NUM_DIRECTED = 23;

    typedef struct packed {
        t_op      op;
        t_channel chan;
        t_pulse   p1, p2, p3, p4;
        logic     typed;
        t_result  want;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    t_op         i_operation  = OP_TICK;
    t_channel    i_channel    = '0;
    t_pulse      i_pulse_1    = '0;
    t_pulse      i_pulse_2    = '0;
    t_pulse      i_pulse_3    = '0;
    t_pulse      i_pulse_4    = '0;
    logic        i_out_stall  = 1'b0;
    logic        i_cfg_valid  = 1'b0;
    t_cfg_idx    i_cfg_index  = CFG_MIN_PULSE;
    logic [15:0] i_cfg_data   = '0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_status;
    logic        o_armed;
    logic [3:0]  o_pwm_levels;
    t_pulse      o_pulse_readback;
    logic        o_cfg_ready;

    // block state as the testbench sees it
    t_pulse  staged_width [CHANNELS];
    t_pulse  live_compare [CHANNELS];
    t_count  frame_ticks = '0;
    logic    armed_now   = 1'b0;
    t_pulse  min_width   = RST_MIN_PULSE;
    t_pulse  max_width   = RST_MAX_PULSE;
    t_count  frame_len   = RST_PERIOD;

    t_result pending_pwm_results [$];
    int      mismatch_count = 0;
    int      cycle_count    = 0;
    int      items_sent     = 0;
    bit      idle_enable    = 1'b1;
    bit      hold_output    = 1'b0;

    t_stim_row directed_rows [NUM_DIRECTED] = '{
        '{OP_TICK, 8'd1, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, '{ST_OK, 1'b0, 4'hF, 16'd1000}},
        '{OP_SET_ONE, 8'd0, 16'd1500, 16'd0, 16'd0, 16'd0, 1'b1,
          '{ST_BAD_CHANNEL, 1'b0, 4'hF, 16'd0}},
        '{OP_SET_ONE, 8'd255, 16'd65535, 16'd0, 16'd0, 16'd0, 1'b1,
          '{ST_BAD_CHANNEL, 1'b0, 4'hF, 16'd0}},
        '{OP_SET_ONE, 8'd5, 16'd1000, 16'd0, 16'd0, 16'd0, 1'b1,
          '{ST_BAD_CHANNEL, 1'b0, 4'hF, 16'd0}},
        '{OP_SET_ONE, 8'd1, 16'd1500, 16'd0, 16'd0, 16'd0, 1'b1,
          '{ST_LOCKED, 1'b0, 4'hF, 16'd1000}},
        '{OP_SET_ONE, 8'd2, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1,
          '{ST_OK, 1'b0, 4'hF, 16'd1000}},
        '{OP_SET_ALL, 8'd3, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1,
          '{ST_OK, 1'b0, 4'hF, 16'd1000}},
        '{OP_SET_ALL, 8'd4, 16'd1000, 16'd1000, 16'd1000, 16'd1001, 1'b1,
          '{ST_LOCKED, 1'b0, 4'hF, 16'd1000}},
        '{OP_ARM, 8'd1, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, '{ST_OK, 1'b1, 4'hF, 16'd1000}},
        '{OP_SET_ONE, 8'd4, 16'd65535, 16'd0, 16'd0, 16'd0, 1'b1,
          '{ST_OK, 1'b1, 4'hF, 16'd2000}},
        '{OP_SET_ALL, 8'd3, 16'd65535, 16'd0, 16'd1500, 16'd1234, 1'b1,
          '{ST_OK, 1'b1, 4'hF, 16'd1500}},
        '{OP_ARM, 8'd2, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1,
          '{ST_ARM_FAILED, 1'b0, 4'hF, 16'd1000}},
        '{OP_ARM, 8'd4, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, '{ST_OK, 1'b1, 4'hF, 16'd1000}},
        '{OP_SET_ONE, 8'd3, 16'd1700, 16'd0, 16'd0, 16'd0, 1'b1,
          '{ST_OK, 1'b1, 4'hF, 16'd1700}},
        '{OP_LOCK, 8'd3, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, '{ST_OK, 1'b0, 4'hF, 16'd1000}},
        '{OP_RSVD_5, 8'd1, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1,
          '{ST_OK, 1'b0, 4'hF, 16'd1000}},
        '{OP_RSVD_7, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, '{ST_OK, 1'b0, 4'hF, 16'd0}},
        '{OP_RSVD_6, 8'd4, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 1'b1,
          '{ST_OK, 1'b0, 4'hF, 16'd1000}},
        '{OP_ARM, 8'd1, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, '0},
        '{OP_SET_ALL, 8'd1, 16'd1999, 16'd2001, 16'd999, 16'd1500, 1'b0, '0},
        '{OP_TICK, 8'd2, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, '0},
        '{OP_SET_ONE, 8'd2, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, '0},
        '{OP_TICK, 8'd4, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 1'b0, '0}
    };

    esc_pwm_arming_controller DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_channel        (i_channel),
        .i_pulse_1        (i_pulse_1),
        .i_pulse_2        (i_pulse_2),
        .i_pulse_3        (i_pulse_3),
        .i_pulse_4        (i_pulse_4),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_armed          (o_armed),
        .o_pwm_levels     (o_pwm_levels),
        .o_pulse_readback (o_pulse_readback),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_pulse bound_width(t_pulse raw);
        if (raw < min_width) return min_width;
        if (raw > max_width) return max_width;
        return raw;
    endfunction

    function automatic void relock_channels();
        foreach (staged_width[i]) staged_width[i] = min_width;
        armed_now = 1'b0;
    endfunction

    function automatic t_result next_pwm_result(t_op op, t_channel chan,
                                                t_pulse p1, t_pulse p2, t_pulse p3, t_pulse p4);
        t_result r;
        t_pulse  req [CHANNELS];
        t_pulse  asked [4];
        t_count  wrap_at;
        logic    refuse;
        logic    all_idle;
        r        = '0;
        refuse   = 1'b0;
        all_idle = 1'b1;
        asked[0] = p1;
        asked[1] = p2;
        asked[2] = p3;
        asked[3] = p4;
        case (op)
            OP_TICK: begin
                wrap_at     = (frame_len == '0) ? t_count'(1) : frame_len;
                frame_ticks = frame_ticks + 16'd1;
                if (frame_ticks >= wrap_at) begin
                    frame_ticks  = '0;
                    live_compare = staged_width;
                end
            end
            OP_LOCK: relock_channels();
            OP_ARM: begin
                foreach (staged_width[i]) begin
                    if (staged_width[i] != min_width) all_idle = 1'b0;
                end
                if (all_idle) begin
                    armed_now = 1'b1;
                end else begin
                    relock_channels();
                    r.status = ST_ARM_FAILED;
                end
            end
            OP_SET_ONE: begin
                if (chan < 1 || chan > CHANNELS) begin
                    r.status = ST_BAD_CHANNEL;
                end else begin
                    req[0] = bound_width(p1);
                    if (!armed_now && req[0] > min_width) begin
                        r.status = ST_LOCKED;
                    end else begin
                        staged_width[chan - 1] = req[0];
                    end
                end
            end
            OP_SET_ALL: begin
                for (int i = 0; i < CHANNELS; i++) begin
                    req[i] = bound_width(asked[(i < 3) ? i : 3]);
                    if (req[i] > min_width) refuse = 1'b1;
                end
                if (!armed_now && refuse) begin
                    r.status = ST_LOCKED;
                end else begin
                    staged_width = req;
                end
            end
            default: ;
        endcase
        for (int i = 0; i < CHANNELS && i < 4; i++) begin
            r.pwm_levels[i] = (frame_ticks < live_compare[i]);
        end
        if (chan >= 1 && chan <= CHANNELS) r.pulse_readback = staged_width[chan - 1];
        r.armed = armed_now;
        return r;
    endfunction

    function automatic t_pulse random_width();
        int lo;
        int hi;
        lo = (min_width < max_width) ? int'(min_width) : int'(max_width);
        hi = (min_width < max_width) ? int'(max_width) : int'(min_width);
        case ($urandom_range(0, 9))
            0: return t_pulse'($urandom);
            1: return min_width;
            2: return max_width;
            3: return t_pulse'($urandom_range(0, lo));
            default: return t_pulse'($urandom_range(lo > 3 ? lo - 3 : 0,
                                                    hi < 65532 ? hi + 3 : 65535));
        endcase
    endfunction

    function automatic t_channel random_channel();
        if ($urandom_range(0, 9) < 8) return t_channel'($urandom_range(0, CHANNELS + 1));
        return t_channel'($urandom);
    endfunction

    task automatic send_item(input t_op op, input t_channel chan, input t_pulse p1,
                             input t_pulse p2, input t_pulse p3, input t_pulse p4,
                             input logic typed, input t_result typed_want);
        int      gap;
        t_result predicted;
        gap = idle_enable ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_channel   <= chan;
        i_pulse_1   <= p1;
        i_pulse_2   <= p2;
        i_pulse_3   <= p3;
        i_pulse_4   <= p4;
        do @(posedge i_clk); while (o_in_stall);
        predicted = next_pwm_result(op, chan, p1, p2, p3, p4);
        pending_pwm_results.push_back(typed ? typed_want : predicted);
        if (op <= OP_SET_ALL) items_sent++;
    endtask

    task automatic send_random_item();
        int  pick;
        t_op op;
        pick = $urandom_range(0, 99);
        if (pick < 38) begin
            op = OP_TICK;
        end else if (pick < 58) begin
            op = OP_SET_ONE;
        end else if (pick < 72) begin
            op = OP_SET_ALL;
        end else if (pick < 80) begin
            op = OP_ARM;
        end else if (pick < 86) begin
            op = OP_LOCK;
        end else if (pick < 92) begin
            op = t_op'($urandom_range(OP_RSVD_5, OP_RSVD_7));
        end else begin
            // lock then arm, so the armed paths get exercised
            send_item(OP_LOCK, random_channel(), random_width(), random_width(),
                      random_width(), random_width(), 1'b0, '0);
            op = OP_ARM;
        end
        send_item(op, random_channel(), random_width(), random_width(),
                  random_width(), random_width(), 1'b0, '0);
    endtask

    task automatic wait_for_idle();
        i_in_valid <= 1'b0;
        while (pending_pwm_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MIN_PULSE: min_width = value;
            CFG_MAX_PULSE: max_width = value;
            CFG_PERIOD:    frame_len = value;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input t_pulse lo, input t_pulse hi, input t_count len,
                                  input bit touch_spare);
        wait_for_idle();
        if (touch_spare) write_register(CFG_SPARE, 16'($urandom));
        write_register(CFG_MIN_PULSE, lo);
        write_register(CFG_MAX_PULSE, hi);
        write_register(CFG_PERIOD, len);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string field_name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field_name,
                     want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_pwm_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: result beat mismatch, expected none, actual status %0d", $time,
                         o_status);
            end else begin
                want = pending_pwm_results.pop_front();
                check_field("status", 16'(want.status), 16'(o_status));
                check_field("armed", 16'(want.armed), 16'(o_armed));
                check_field("pwm_levels", 16'(want.pwm_levels), 16'(o_pwm_levels));
                check_field("pulse_readback", want.pulse_readback, o_pulse_readback);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // output stall: random per beat, one long hold-off on request
    initial begin
        int stall_len;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_output) begin
                hold_output = 1'b0;
                stall_len   = HOLD_CYCLES;
            end else begin
                stall_len = idle_enable ? $urandom_range(0, 4) : 0;
            end
            if (stall_len > 0) begin
                i_out_stall <= 1'b1;
                repeat (stall_len) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin
        int lo;
        int goal;
        bit paused;
        paused = 1'b0;
        foreach (staged_width[i]) begin
            staged_width[i] = RST_MIN_PULSE;
            live_compare[i] = RST_MIN_PULSE;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].op, directed_rows[i].chan, directed_rows[i].p1,
                      directed_rows[i].p2, directed_rows[i].p3, directed_rows[i].p4,
                      directed_rows[i].typed, directed_rows[i].want);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: apply_settings(16'd2, 16'd12, 16'd10, 1'b1);
                1: apply_settings(16'd0, 16'hFFFF, 16'd1, 1'b0);
                2: apply_settings(16'hFFFF, 16'hFFFF, 16'd3, 1'b0);
                3: apply_settings(16'd9, 16'd5, 16'd8, 1'b0);       // max below min
                4: apply_settings(16'd0, 16'd20, 16'hFFFF, 1'b0);
                5: apply_settings(16'd0, 16'd20, 16'd4, 1'b0);      // period under counter
                6: apply_settings(16'd3, 16'd6, 16'd0, 1'b0);       // period zero
                default: begin
                    lo = $urandom_range(0, 30);
                    apply_settings(t_pulse'(lo), t_pulse'(lo + $urandom_range(0, 30)),
                                   t_count'($urandom_range(1, 40)), 1'b0);
                end
            endcase
            idle_enable = (phase != 1 && phase != 7);
            if (phase == 5) hold_output = 1'b1;
            goal = items_sent + ((phase == 0) ? 60 : 40);
            while (items_sent < goal) begin
                send_random_item();
                if (phase == 0 && !paused && items_sent >= 30) begin
                    paused = 1'b1;
                    wait_for_idle();
                end
            end
        end

        wait_for_idle();
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
